// ===== rtl/core/addressed_frame_receiver_crc8_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the addressed frame receiver
// Concurrent checks that are clocked and disabled in reset; compile them
// out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_FRAME_RECEIVER_CRC8_CORE_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_CRC8_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on the given clock, disabled while the given reset is low.
`define AFRC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on the block clock and reset.
`define AFRC_ASSERT(lbl, prop, msg) \
  `AFRC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define AFRC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define AFRC_ASSERT(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/afrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrc_pkg: shared types and helpers
// Request codes, internal op and event encodings, queue entry type, CRC-8
// byte update and the known command id lookup.
// ----------------------------------------------------------------------------
package afrc_pkg;

  localparam int unsigned FrameMaxDef = 254;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] CrcPoly     = 8'h31;
  localparam logic [7:0] CrcInit     = 8'hFF;
  localparam logic [7:0] MinFrameLen = 8'd4;

  localparam logic [1:0] ReqByte    = 2'd0;
  localparam logic [1:0] ReqTimeout = 2'd1;
  localparam logic [1:0] ReqRead    = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TIMEOUT,
    OP_READ,
    OP_NONE
  } afrc_op_e;

  typedef enum logic [2:0] {
    EV_ABSORBED,
    EV_GOOD_KNOWN,
    EV_GOOD_UNKNOWN,
    EV_CRC_ERROR,
    EV_BAD_LENGTH,
    EV_ADDR_IGNORED,
    EV_TIMEOUT,
    EV_READ_DATA
  } afrc_event_e;

  // data carries the received byte or the read position, by op
  typedef struct packed {
    afrc_op_e   op;
    logic [7:0] data;
  } afrc_item_t;

  typedef struct packed {
    logic       valid;
    afrc_item_t item;
  } afrc_queue_t;

  // One byte through CRC-8, polynomial 0x31, MSB first
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic id_known(logic [7:0] id);
    logic hit;
    case (id)
      8'h02, 8'h04, 8'h06, 8'h08, 8'h10, 8'h12,
      8'h14, 8'h16, 8'h18, 8'h30, 8'h32: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/core/afrc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrc_if: channel interfaces
// Valid/ready channels for requests, results and the address register write.
// ----------------------------------------------------------------------------
interface afrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, req_type, rx_byte, read_index, input ready);
  modport sink   (input valid, req_type, rx_byte, read_index, output ready);
endinterface

interface afrc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] frame_id;
  logic [7:0] frame_length;
  logic [7:0] nak_value;
  logic [7:0] read_data;

  modport source (output valid, event_res, frame_id, frame_length, nak_value,
                  read_data, input ready);
  modport sink   (input valid, event_res, frame_id, frame_length, nak_value,
                  read_data, output ready);
endinterface

interface afrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] own_address;

  modport source (output valid, own_address, input ready);
  modport sink   (input valid, own_address, output ready);
endinterface

// ===== rtl/core/afrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrc_front: request intake
// Decode each request into an op and queue it for the execute side.
// ----------------------------------------------------------------------------
module afrc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  afrc_in_if.sink               req_i,
  output afrc_pkg::afrc_queue_t q_o,
  input  logic                  pop_i
);
  import afrc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  afrc_item_t            slot_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       used_q, used_d;
  afrc_item_t            item;
  logic                  push;

  // Classify: pick the op and the one data byte it needs
  always_comb begin
    item.op   = OP_NONE;
    item.data = req_i.rx_byte;
    case (req_i.req_type)
      ReqByte:    item.op = OP_BYTE;
      ReqTimeout: item.op = OP_TIMEOUT;
      ReqRead: begin
        item.op   = OP_READ;
        item.data = req_i.read_index;
      end
      default:    item.op = OP_NONE;
    endcase
  end

  assign req_i.ready = (used_q != CntW'(QueueDepth));
  assign push        = req_i.valid && req_i.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    used_d   = used_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop_i})
      2'b10:   used_d = used_q + CntW'(1);
      2'b01:   used_d = used_q - CntW'(1);
      default: used_d = used_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  assign q_o.valid = (used_q != '0);
  assign q_o.item  = slot_q[rd_ptr_q];

endmodule

// ===== rtl/core/afrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrc_back: frame execution
// Run the reception state, the CRC and the frame store, one op per cycle while
// the result stage is free, into a registered result stage.
// ----------------------------------------------------------------------------
module afrc_back #(
  parameter int unsigned FRAME_MAX = afrc_pkg::FrameMaxDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            own_address_i,
  input  afrc_pkg::afrc_queue_t q_i,
  output logic                  pop_o,
  afrc_out_if.source            res_o
);
  import afrc_pkg::*;

  localparam int unsigned AddrW     = $clog2(FRAME_MAX);
  localparam logic [7:0]  FrameMaxB = 8'(FRAME_MAX);
  localparam logic [7:0]  PosAddr   = 8'd0;
  localparam logic [7:0]  PosId     = 8'd1;
  localparam logic [7:0]  PosLen    = 8'd2;

  // Reception state
  logic [7:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  wfill_q, wfill_d;  // store positions written since the last match
  logic [7:0]  id_q, id_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  nak_q, nak_d;

  // Frame store
  logic [7:0]  store_q [FRAME_MAX];
  logic [7:0]  mem_rd_q;

  // Result stage
  logic        valid_q;
  afrc_event_e ev_q, ev_d;
  logic [7:0]  fid_q, fid_d;
  logic [7:0]  flen_q, flen_d;
  logic [7:0]  nakv_q, nakv_d;
  logic        rd_sel_q, rd_sel_d;
  logic [7:0]  rd_const_q, rd_const_d;

  logic        fire;
  logic        wr_en;
  logic        rd_en;
  logic [7:0]  data;
  logic [7:0]  pos;
  logic [8:0]  pos_next;
  logic [7:0]  crc_base;
  logic [7:0]  crc_step;

  assign fire  = q_i.valid && (!valid_q || res_o.ready);
  assign pop_o = fire;
  assign data  = q_i.item.data;

  assign pos      = (count_q >= FrameMaxB) ? '0 : count_q;
  assign pos_next = {1'b0, pos} + 9'd1;
  assign crc_base = (pos == PosAddr) ? CrcInit : crc_q;
  assign crc_step = crc8_update(crc_base, data);

  always_comb begin
    count_d    = count_q;
    crc_d      = crc_q;
    wfill_d    = wfill_q;
    id_d       = id_q;
    len_d      = len_q;
    nak_d      = nak_q;
    ev_d       = EV_ABSORBED;
    fid_d      = '0;
    flen_d     = '0;
    nakv_d     = '0;
    rd_sel_d   = 1'b0;
    rd_const_d = '0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (q_i.item.op)
      OP_TIMEOUT: begin
        count_d = '0;
        crc_d   = CrcInit;
        ev_d    = EV_TIMEOUT;
      end
      OP_READ: begin
        ev_d = EV_READ_DATA;
        if (data >= FrameMaxB) begin
          rd_const_d = '0;
        end else if (data == PosId && wfill_q < PosLen) begin
          // id slot holds the frame maximum until the id byte lands
          rd_const_d = FrameMaxB;
        end else if (data >= PosLen && data >= wfill_q) begin
          rd_const_d = '0;
        end else begin
          rd_sel_d = 1'b1;
          rd_en    = 1'b1;
        end
      end
      OP_BYTE: begin
        wr_en   = 1'b1;
        count_d = pos_next[7:0];
        if (pos != PosAddr) begin
          wfill_d = pos_next[7:0];
        end
        case (pos)
          PosAddr: begin
            if (data == own_address_i) begin
              crc_d   = crc_step;
              wfill_d = 8'd1;
            end else begin
              count_d = '0;
              crc_d   = CrcInit;
              ev_d    = EV_ADDR_IGNORED;
            end
          end
          PosId: begin
            crc_d = crc_step;
            id_d  = data;
          end
          PosLen: begin
            if (data > FrameMaxB || data < MinFrameLen) begin
              fid_d   = id_q;
              flen_d  = data;
              ev_d    = EV_BAD_LENGTH;
              count_d = '0;
              crc_d   = CrcInit;
            end else begin
              crc_d = crc_step;
              len_d = data;
            end
          end
          default: begin
            if (pos_next >= {1'b0, len_q}) begin
              fid_d  = id_q;
              flen_d = len_q;
              if (crc_q == data) begin
                ev_d = id_known(id_q) ? EV_GOOD_KNOWN : EV_GOOD_UNKNOWN;
              end else begin
                ev_d   = EV_CRC_ERROR;
                nakv_d = nak_q;
                nak_d  = nak_q + 8'd1;
              end
              count_d = '0;
              crc_d   = CrcInit;
            end else begin
              crc_d = crc_step;
            end
          end
        endcase
      end
      default: begin
        ev_d = EV_ABSORBED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= CrcInit;
      wfill_q <= '0;
      nak_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
        crc_q   <= crc_d;
        wfill_q <= wfill_d;
        nak_q   <= nak_d;
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      id_q       <= id_d;
      len_q      <= len_d;
      ev_q       <= ev_d;
      fid_q      <= fid_d;
      flen_q     <= flen_d;
      nakv_q     <= nakv_d;
      rd_sel_q   <= rd_sel_d;
      rd_const_q <= rd_const_d;
    end
  end

  // Single port store: one write or one registered read per op
  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      store_q[pos[AddrW-1:0]] <= data;
    end
    if (fire && rd_en) begin
      mem_rd_q <= store_q[data[AddrW-1:0]];
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.event_res    = ev_q;
  assign res_o.frame_id     = fid_q;
  assign res_o.frame_length = flen_q;
  assign res_o.nak_value    = nakv_q;
  assign res_o.read_data    = rd_sel_q ? mem_rd_q : rd_const_q;

endmodule

// ===== rtl/core/addressed_frame_receiver_crc8_core.sv =====
`timescale 1ns / 1ps
// Addressed frame receiver with CRC-8 check. Each request (received byte,
// receive timeout, or read of a stored frame byte) gives exactly one result,
// in order. The block takes one request per clock cycle for as long as
// results are taken. Each accepted request is first written into the intake
// queue and then run through the execute stage into the result register,
// which holds it until it is taken. The CRC update, the byte count and the
// single access to the single-port frame store all happen in that execute
// stage. A two-entry queue sits between intake and execution, so a stalled
// result holds up intake only once the queue is full. The frame store has
// no clearing pass after reset: a count of positions written since the last
// address match stands in for the clear that a match implies, so the block
// is ready straight out of reset.
// Write the address register only while no request is in flight: a write
// takes effect at once and would otherwise apply to requests already
// queued. Its write channel never stalls.
// ----------------------------------------------------------------------------
// addressed_frame_receiver_crc8_core: top level
// Intake queue, execute stage with frame store, and the address register.
// ----------------------------------------------------------------------------
`include "addressed_frame_receiver_crc8_core_macros.svh"

module addressed_frame_receiver_crc8_core #(
  parameter int unsigned FRAME_MAX = afrc_pkg::FrameMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  afrc_in_if.sink     rx_req_i,
  afrc_out_if.source  res_o,
  afrc_cfg_if.sink    cfg_i
);
  import afrc_pkg::*;

  logic [7:0]  own_address_q;
  afrc_queue_t q;
  logic        q_pop;

  // Address register: always ready, reset to address one
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= 8'd1;
    end else if (cfg_i.valid) begin
      own_address_q <= cfg_i.own_address;
    end
  end

  // Intake: decode each request and hold it until the execute stage is free
  afrc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rx_req_i),
    .q_o    (q),
    .pop_i  (q_pop)
  );

  // Execute: reception state, CRC, frame store and the result register
  afrc_back #(
    .FRAME_MAX (FRAME_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .own_address_i (own_address_q),
    .q_i           (q),
    .pop_o         (q_pop),
    .res_o         (res_o)
  );

  // Never pop an empty queue
  `AFRC_ASSERT(a_pop_has_item, q_pop |-> q.valid, "queue popped while empty")

  // Never overwrite a result that is still waiting
  `AFRC_ASSERT(a_pop_needs_room, q_pop |-> (!res_o.valid || res_o.ready), "result overwritten while stalled")

  // An accepted request is queued by the next cycle
  `AFRC_ASSERT(a_accept_queued, (rx_req_i.valid && rx_req_i.ready) |=> q.valid, "accepted request lost before execution")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: addressed frame receiver with CRC-8 check
// Streams framed bytes, receive timeouts and store reads into the block under
// random stalls on both channels. Every accepted request is run through a
// local model of the receiver, and each result is checked in order against
// the model's answer. The slave address is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import afrc_pkg::*;

  localparam int unsigned FrameMax   = FrameMaxDef;
  localparam logic [1:0]  ReqUnused  = 2'd3;
  localparam int unsigned IdleLimit  = 500;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned NakBurst   = 268;
  localparam logic [87:0] KnownCmds  = {8'h02, 8'h04, 8'h06, 8'h08, 8'h10, 8'h12,
                                        8'h14, 8'h16, 8'h18, 8'h30, 8'h32};

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } rx_request_t;

  typedef struct packed {
    afrc_event_e ev;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [7:0]  nak;
    logic [7:0]  rd;
  } frame_reply_t;

  // Clock, reset and the block's channels
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  afrc_in_if  rx_if ();
  afrc_out_if res_if ();
  afrc_cfg_if cfg_if ();

  // Values driven onto the channels; all known from time zero
  logic       in_valid  = 1'b0;
  logic [1:0] in_req    = ReqByte;
  logic [7:0] in_byte   = 8'h00;
  logic [7:0] in_index  = 8'h00;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_addr  = 8'h00;

  assign rx_if.valid      = in_valid;
  assign rx_if.req_type   = in_req;
  assign rx_if.rx_byte    = in_byte;
  assign rx_if.read_index = in_index;
  assign res_if.ready     = out_ready;
  assign cfg_if.valid     = cfg_valid;
  assign cfg_if.own_address = cfg_addr;

  addressed_frame_receiver_crc8_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_req_i (rx_if),
    .res_o    (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Requests waiting to be offered, and replies owed by the block
  rx_request_t  rx_pending[$];
  frame_reply_t reply_expected[$];

  // Receiver state as the model sees it
  logic [7:0] addr_model = 8'h01;
  logic [7:0] rx_count   = 8'h00;
  logic [7:0] rx_crc     = CrcInit;
  logic [7:0] nak_count  = 8'h00;
  logic [7:0] rx_store [FrameMax];

  // Stimulus bookkeeping
  logic [7:0]  gen_addr    = 8'h01;
  int unsigned stim_count  = 0;
  int unsigned phase_end   = 0;
  bit          steady_flow = 1'b0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  rx_request_t  next_req;
  frame_reply_t want;

  // CRC-8, polynomial 0x31, most significant bit first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    repeat (8) acc = {acc[6:0], 1'b0} ^ (acc[7] ? CrcPoly : 8'h00);
    return acc;
  endfunction

  function automatic bit cmd_is_known(logic [7:0] id);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < 11; i++)
      if (KnownCmds[i*8 +: 8] == id) hit = 1'b1;
    return hit;
  endfunction

  function automatic void frame_restart();
    rx_count = 8'h00;
    rx_crc   = CrcInit;
  endfunction

  // Advance the receiver by one request and return the reply it owes
  function automatic frame_reply_t receiver_predict(rx_request_t rq);
    frame_reply_t r;
    int unsigned  pos;
    logic [7:0]   frame_len;
    r.ev  = EV_ABSORBED;
    r.id  = 8'h00;
    r.len = 8'h00;
    r.nak = 8'h00;
    r.rd  = 8'h00;
    case (rq.req)
      ReqTimeout: begin
        frame_restart();
        r.ev = EV_TIMEOUT;
      end
      ReqRead: begin
        // out of range reads answer zero
        if (rq.read_index < FrameMax) r.rd = rx_store[rq.read_index];
        r.ev = EV_READ_DATA;
      end
      ReqByte: begin
        pos = rx_count;
        if (pos >= FrameMax) begin
          frame_restart();
          pos = 0;
        end
        rx_store[pos] = rq.rx_byte;
        rx_count = 8'(pos + 1);
        if (pos == 0) begin
          if (rq.rx_byte == addr_model) begin
            // a match presets the id slot and clears the rest of the store
            rx_store[1] = 8'(FrameMax);
            for (int i = 2; i < FrameMax; i++) rx_store[i] = 8'h00;
            rx_crc = crc8_step(CrcInit, rq.rx_byte);
          end else begin
            frame_restart();
            r.ev = EV_ADDR_IGNORED;
          end
        end else if (pos == 1) begin
          rx_crc = crc8_step(rx_crc, rq.rx_byte);
        end else if (pos == 2) begin
          if (rq.rx_byte > FrameMax || rq.rx_byte < MinFrameLen) begin
            r.id  = rx_store[1];
            r.len = rq.rx_byte;
            r.ev  = EV_BAD_LENGTH;
            frame_restart();
          end else begin
            rx_crc = crc8_step(rx_crc, rq.rx_byte);
          end
        end else begin
          frame_len = rx_store[2];
          if (pos + 1 >= frame_len) begin
            r.id  = rx_store[1];
            r.len = frame_len;
            if (rx_crc == rq.rx_byte) begin
              r.ev = cmd_is_known(r.id) ? EV_GOOD_KNOWN : EV_GOOD_UNKNOWN;
            end else begin
              // report the count as it stood, then bump it
              r.ev = EV_CRC_ERROR;
              r.nak = nak_count;
              nak_count = nak_count + 8'd1;
            end
            frame_restart();
          end else begin
            rx_crc = crc8_step(rx_crc, rq.rx_byte);
          end
        end
      end
      default: ;  // unused request code: no state change
    endcase
    return r;
  endfunction

  // Driver: offer the next pending request, hold it until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= ReqByte;
      in_byte  <= 8'h00;
      in_index <= 8'h00;
    end else begin
      if (in_valid && rx_if.ready)
        reply_expected.push_back(receiver_predict({in_req, in_byte, in_index}));
      if (!in_valid || rx_if.ready) begin
        if (rx_pending.size() != 0 && (steady_flow || $urandom_range(99) >= 8)) begin
          next_req = rx_pending.pop_front();
          in_valid <= 1'b1;
          in_req   <= next_req.req;
          in_byte  <= next_req.rx_byte;
          in_index <= next_req.read_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, exp_val,
               act_val);
      error_count++;
    end
  endtask

  // Monitor: take results with random back-pressure and check them in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (res_if.valid && out_ready) begin
        if (reply_expected.size() == 0) begin
          $display("%0t ns: unrequested result, expected none actual event %0d", $time,
                   res_if.event_res);
          error_count++;
        end else begin
          want = reply_expected.pop_front();
          compare_field("event_res", 8'(want.ev), 8'(res_if.event_res));
          compare_field("frame_id", want.id, res_if.frame_id);
          compare_field("frame_length", want.len, res_if.frame_length);
          compare_field("nak_value", want.nak, res_if.nak_value);
          compare_field("read_data", want.rd, res_if.read_data);
        end
      end
      out_ready <= steady_flow || ($urandom_range(99) >= 8);
    end
  end

  // Watchdog: drop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && rx_if.ready) || (res_if.valid && out_ready) ||
        (cfg_valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("[addressed_frame_receiver_crc8_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Request builders; unused fields carry random filler
  task automatic queue_byte(logic [7:0] b);
    rx_pending.push_back({ReqByte, b, 8'($urandom)});
    stim_count++;
  endtask

  task automatic queue_read(logic [7:0] idx);
    rx_pending.push_back({ReqRead, 8'($urandom), idx});
    stim_count++;
  endtask

  task automatic queue_timeout();
    rx_pending.push_back({ReqTimeout, 8'($urandom), 8'($urandom)});
    stim_count++;
  endtask

  task automatic queue_unused();
    rx_pending.push_back({ReqUnused, 8'($urandom), 8'($urandom)});
  endtask

  // Whole frame with a correct CRC, or a damaged one if asked
  task automatic queue_frame(logic [7:0] addr, logic [7:0] id, logic [7:0] len,
                             bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crc8_step(CrcInit, addr);
    crc = crc8_step(crc, id);
    crc = crc8_step(crc, len);
    queue_byte(addr);
    queue_byte(id);
    queue_byte(len);
    for (int i = 3; i < int'(len) - 1; i++) begin
      b = 8'($urandom);
      crc = crc8_step(crc, b);
      queue_byte(b);
    end
    if (corrupt) crc ^= 8'($urandom_range(255, 1));
    queue_byte(crc);
  endtask

  function automatic logic [7:0] pick_cmd();
    if ($urandom_range(1) == 0) return KnownCmds[$urandom_range(10)*8 +: 8];
    return 8'($urandom);
  endfunction

  // Mostly well-formed frames; the rest broken frames, reads and noise
  task automatic queue_random_item();
    int unsigned kind;
    logic [7:0]  len;
    kind = $urandom_range(99);
    if (kind < 68) begin
      len = ($urandom_range(99) < 88) ? 8'($urandom_range(12, 4)) : 8'($urandom_range(48, 13));
      queue_frame(($urandom_range(99) < 92) ? gen_addr : 8'($urandom), pick_cmd(), len,
                  $urandom_range(99) < 20);
    end else if (kind < 76) begin
      len = 8'($urandom_range(4));
      if (len == 8'd4) len = 8'hFF;
      queue_byte(gen_addr);
      queue_byte(pick_cmd());
      queue_byte(len);
    end else if (kind < 82) begin
      // frame cut short by a receive timeout
      len = 8'($urandom_range(20, 6));
      queue_byte(gen_addr);
      queue_byte(pick_cmd());
      queue_byte(len);
      repeat ($urandom_range(int'(len) - 5)) queue_byte(8'($urandom));
      queue_timeout();
    end else if (kind < 92) begin
      queue_read(($urandom_range(19) == 0) ? 8'($urandom_range(255, 254))
                                            : 8'($urandom_range(253)));
    end else if (kind < 95) begin
      queue_timeout();
    end else if (kind < 97) begin
      queue_unused();
    end else begin
      queue_byte(8'($urandom));
    end
  endtask

  // Hold until every request is taken and answered, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (rx_pending.size() != 0 || in_valid || reply_expected.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_own_address(logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_addr  <= a;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_valid  <= 1'b0;
    addr_model = a;
    gen_addr   = a;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a matching frame first, so every store entry is written
    // before any read
    queue_frame(8'h01, 8'h02, 8'd4, 1'b0);       // good frame, known id
    queue_read(8'd0);
    queue_read(8'd253);
    queue_read(8'd254);                          // out of range
    queue_frame(8'h01, 8'h00, 8'd4, 1'b0);       // good frame, unknown id
    queue_frame(8'h01, 8'h32, 8'd4, 1'b1);       // CRC error, first nak
    queue_byte(8'hFE);                           // address mismatch
    queue_byte(8'h01);                           // length below minimum
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h01);                           // timeout mid frame
    queue_byte(8'h10);
    queue_timeout();
    queue_byte(8'h01);                           // largest length is taken
    queue_byte(8'h30);
    queue_byte(8'(FrameMax));
    queue_byte(8'h5A);
    queue_timeout();
    queue_read(8'd2);
    queue_unused();
    wait_idle();

    // Reset address, random traffic
    phase_end = stim_count + PhaseItems;
    while (stim_count < phase_end) queue_random_item();
    wait_idle();

    // Lowest address, random traffic
    write_own_address(8'h00);
    phase_end = stim_count + PhaseItems;
    while (stim_count < phase_end) queue_random_item();
    wait_idle();

    // Highest address, back-to-back short frames with no stalls, enough
    // CRC errors to wrap the nak count, a good frame now and then
    write_own_address(8'hFF);
    steady_flow = 1'b1;
    for (int i = 0; i < int'(NakBurst) - int'(nak_count); i++)
      queue_frame(gen_addr, pick_cmd(), 8'd4, (i % 32) != 31);
    wait_idle();
    steady_flow = 1'b0;

    // Random address, random traffic
    write_own_address(8'($urandom_range(254, 1)));
    phase_end = stim_count + PhaseItems;
    while (stim_count < phase_end) queue_random_item();
    wait_idle();

    if (error_count == 0) begin
      $display("[addressed_frame_receiver_crc8_core] OK");
    end else begin
      $display("[addressed_frame_receiver_crc8_core] ERROR");
    end
    $finish;
  end

endmodule
